@@ design/les_pkg.sv @@
package les_pkg;

  // input item operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] CFG_COEF_A     = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_COEF_B     = 8'd1;
  localparam logic [CfgIdxW-1:0] CFG_COEF_C     = 8'd2;
  localparam logic [CfgIdxW-1:0] CFG_STEP_LIMIT = 8'd3;

  // configuration reset values
  localparam logic signed [31:0] COEF_A_RST     = 32'sd655360;
  localparam logic signed [31:0] COEF_B_RST     = 32'sd1835008;
  localparam logic signed [31:0] COEF_C_RST     = 32'sd174763;
  localparam logic [19:0]        STEP_LIMIT_RST = 20'd1000;

  // time step 0.01 in Q16.16
  localparam logic signed [31:0] DT_Q16 = 32'sd655;

  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  // products of one Euler update, in issue order
  typedef enum logic [2:0] {
    OP_FX = 3'd0,  // a * (y - x)
    OP_FY = 3'd1,  // x * (b - z), then minus y
    OP_XY = 3'd2,  // x * y
    OP_CZ = 3'd3,  // c * z, then xy minus cz
    OP_NX = 3'd4,  // fx * dt, added to x
    OP_NY = 3'd5,  // fy * dt, added to y
    OP_NZ = 3'd6   // fz * dt, added to z
  } mul_op_e;

  typedef struct packed {
    logic              operation;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
  } in_item_t;

  typedef struct packed {
    logic [30:0]        time_now;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               last_step;
  } out_item_t;

  // saturating add or subtract of two signed 32-bit values
  function automatic logic signed [31:0] sat_addsub(logic signed [31:0] p,
                                                    logic signed [31:0] q,
                                                    logic sub);
    logic [32:0] qx;
    logic [32:0] s;
    qx = sub ? ~{q[31], q} : {q[31], q};
    s  = {p[31], p} + qx + {32'd0, sub};
    if (s[32] != s[31]) begin
      return s[32] ? S32_MIN : S32_MAX;
    end
    return s[31:0];
  endfunction

endpackage

@@ design/les_sermul.sv @@
module les_sermul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] mcand_i,
  input  logic signed [31:0] mplier_i,
  output logic               done_o,
  output logic signed [31:0] prod_o
);
  import les_pkg::*;

  logic               busy_q, rnd_q, done_q;
  logic [4:0]         cnt_q;
  logic signed [31:0] mcand_q;
  logic [31:0]        mplier_q;
  logic [32:0]        acc_q;
  logic signed [31:0] prod_q;

  logic        last_bit;
  logic [32:0] ext, addend, sum;
  logic [63:0] full;
  logic [47:0] rsum;
  logic signed [31:0] rnd_sat;

  // one multiplier bit per cycle, sign bit weighs negative
  assign last_bit = (cnt_q == 5'd31);
  assign ext      = {mcand_q[31], mcand_q};
  always_comb begin
    addend = '0;
    if (mplier_q[0]) begin
      addend = last_bit ? (~ext + 33'd1) : ext;
    end
    sum = acc_q + addend;
  end

  // round half up, then saturate to 32 bits
  always_comb begin
    full = {acc_q[31:0], mplier_q};
    rsum = full[63:16] + {47'd0, full[15]};
    if (rsum[47:31] != {17{rsum[31]}}) begin
      rnd_sat = rsum[47] ? S32_MIN : S32_MAX;
    end else begin
      rnd_sat = rsum[31:0];
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rnd_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= rnd_q;
      rnd_q  <= busy_q && last_bit;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (last_bit) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // shift datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q  <= mcand_i;
      mplier_q <= mplier_i;
      acc_q    <= '0;
    end else if (busy_q) begin
      acc_q    <= {sum[32], sum[32:1]};
      mplier_q <= {sum[0], mplier_q[31:1]};
    end
    if (rnd_q) begin
      prod_q <= rnd_sat;
    end
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

@@ design/lorenz_euler_step_top.sv @@
// a load item, or a step item once the last point is reached, goes straight to the
//   finish state; its result is registered there once the output slot is free
// a step item first computes seven products, one after another, through one
//   bit-serial 32x32 multiplier, one bit a cycle
// items are taken only in idle, never before the last result is registered
// reset: point, time and step count clear to zero; coefficients return to defaults
module lorenz_euler_step_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  les_pkg::in_item_t           in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output les_pkg::out_item_t          out_item_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [les_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                 cfg_data_i
);
  import les_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_FIN   = 4'b1000
  } state_e;

  state_e             state_q;
  mul_op_e            op_q;
  logic signed [31:0] coef_a_q, coef_b_q, coef_c_q;
  logic [19:0]        limit_q;
  logic signed [31:0] x_q, y_q, z_q;
  logic signed [31:0] t0_q, t1_q, t2_q;
  logic [31:0]        time_q;
  logic [19:0]        count_q;
  logic               out_valid_q;
  out_item_t          out_item_q;

  logic               at_last, slot_free, in_acc;
  logic               mul_start, mul_done;
  logic signed [31:0] mul_a, mul_b, mul_p;
  logic signed [31:0] wb_p, wb_q, wb_val;
  logic               wb_sub;

  assign at_last     = ({1'b0, count_q} + 21'd1) >= {1'b0, limit_q};
  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign mul_start   = (state_q == ST_ISSUE);

  // multiplier operands for each product
  always_comb begin
    case (op_q)
      OP_FX: begin
        mul_a = coef_a_q;
        mul_b = sat_addsub(y_q, x_q, 1'b1);
      end
      OP_FY: begin
        mul_a = x_q;
        mul_b = sat_addsub(coef_b_q, z_q, 1'b1);
      end
      OP_XY: begin
        mul_a = x_q;
        mul_b = y_q;
      end
      OP_CZ: begin
        mul_a = coef_c_q;
        mul_b = z_q;
      end
      OP_NX: begin
        mul_a = t0_q;
        mul_b = DT_Q16;
      end
      OP_NY: begin
        mul_a = t1_q;
        mul_b = DT_Q16;
      end
      OP_NZ: begin
        mul_a = t2_q;
        mul_b = DT_Q16;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  les_sermul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (mul_a),
    .mplier_i (mul_b),
    .done_o   (mul_done),
    .prod_o   (mul_p)
  );

  // saturating add or subtract after the FY, CZ and NX to NZ products
  always_comb begin
    wb_p   = mul_p;
    wb_q   = y_q;
    wb_sub = 1'b1;
    case (op_q)
      OP_FY: begin
        wb_p   = mul_p;
        wb_q   = y_q;
        wb_sub = 1'b1;
      end
      OP_CZ: begin
        wb_p   = t2_q;
        wb_q   = mul_p;
        wb_sub = 1'b1;
      end
      OP_NX: begin
        wb_p   = x_q;
        wb_q   = mul_p;
        wb_sub = 1'b0;
      end
      OP_NY: begin
        wb_p   = y_q;
        wb_q   = mul_p;
        wb_sub = 1'b0;
      end
      OP_NZ: begin
        wb_p   = z_q;
        wb_q   = mul_p;
        wb_sub = 1'b0;
      end
      default: begin
        wb_p   = mul_p;
        wb_q   = y_q;
        wb_sub = 1'b1;
      end
    endcase
    wb_val = sat_addsub(wb_p, wb_q, wb_sub);
  end

  // sequencer, configuration and integrator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_FX;
      coef_a_q    <= COEF_A_RST;
      coef_b_q    <= COEF_B_RST;
      coef_c_q    <= COEF_C_RST;
      limit_q     <= STEP_LIMIT_RST;
      x_q         <= '0;
      y_q         <= '0;
      z_q         <= '0;
      time_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_COEF_A:     coef_a_q <= cfg_data_i;
          CFG_COEF_B:     coef_b_q <= cfg_data_i;
          CFG_COEF_C:     coef_c_q <= cfg_data_i;
          CFG_STEP_LIMIT: limit_q  <= cfg_data_i[19:0];
          default: ;
        endcase
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_item_i.operation == OP_LOAD) begin
              x_q     <= in_item_i.start_x;
              y_q     <= in_item_i.start_y;
              z_q     <= in_item_i.start_z;
              time_q  <= '0;
              count_q <= '0;
              state_q <= ST_FIN;
            end else if (at_last) begin
              state_q <= ST_FIN;
            end else begin
              op_q    <= OP_FX;
              state_q <= ST_ISSUE;
            end
          end
        end
        ST_ISSUE: begin
          state_q <= ST_WAIT;
        end
        ST_WAIT: begin
          if (mul_done) begin
            case (op_q)
              OP_NX: x_q <= wb_val;
              OP_NY: y_q <= wb_val;
              OP_NZ: z_q <= wb_val;
              default: ;
            endcase
            if (op_q == OP_NZ) begin
              time_q  <= time_q + 32'(DT_Q16);
              count_q <= count_q + 20'd1;
              state_q <= ST_FIN;
            end else begin
              op_q    <= mul_op_e'(op_q + 3'd1);
              state_q <= ST_ISSUE;
            end
          end
        end
        ST_FIN: begin
          if (slot_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      // output register
      if (state_q == ST_FIN && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // intermediate derivatives and result payload
  always_ff @(posedge clk_i) begin
    if (state_q == ST_WAIT && mul_done) begin
      case (op_q)
        OP_FX: t0_q <= mul_p;
        OP_FY: t1_q <= wb_val;
        OP_XY: t2_q <= mul_p;
        OP_CZ: t2_q <= wb_val;
        default: ;
      endcase
    end
    if (state_q == ST_FIN && slot_free) begin
      out_item_q.time_now  <= time_q[30:0];
      out_item_q.pos_x     <= x_q;
      out_item_q.pos_y     <= y_q;
      out_item_q.pos_z     <= z_q;
      out_item_q.last_step <= at_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("sequencer state not one-hot");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == ST_WAIT)) else $error("product done outside wait");

  a_time_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WAIT && mul_done && op_q == OP_NZ)
    |=> (time_q == $past(time_q) + 32'(DT_Q16)))
    else $error("time did not advance by one step");
`endif

endmodule

@@ dv/lorenz_euler_step_top_tb.sv @@
`timescale 1ns / 100ps

module lorenz_euler_step_top_tb;
  import les_pkg::*;

  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned TailCycles = 10;
  localparam logic signed [31:0] Q_ONE = 32'sd65536;
  // spread of a typical starting point, +-30.0
  localparam int unsigned StartSpan = 30 * 65536;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  in_item_t           in_item_i;
  logic               out_valid_o;
  logic               out_ready_i;
  out_item_t          out_item_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [31:0]        cfg_data_i;

  int unsigned idle_pct = 20;
  int unsigned stall_pct = 20;
  int unsigned n_mismatch = 0;
  out_item_t   points_due[$];

  // predicted block state and registers
  logic signed [31:0] sigma_q = COEF_A_RST;
  logic signed [31:0] rho_q   = COEF_B_RST;
  logic signed [31:0] beta_q  = COEF_C_RST;
  logic [19:0]        limit_q = STEP_LIMIT_RST;
  logic signed [31:0] px_q = '0;
  logic signed [31:0] py_q = '0;
  logic signed [31:0] pz_q = '0;
  logic [31:0]        clock_q = '0;
  logic [19:0]        steps_q = '0;

  lorenz_euler_step_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // fixed-point helpers
  function automatic longint sat32(longint v);
    if (v > longint'(S32_MAX)) return longint'(S32_MAX);
    if (v < longint'(S32_MIN)) return longint'(S32_MIN);
    return v;
  endfunction

  // q16.16 product, rounded half up, saturated
  function automatic longint qmul(longint p, longint q);
    return sat32((p * q + 32768) >>> 16);
  endfunction

  function automatic logic at_last_point();
    return ({1'b0, steps_q} + 21'd1) >= {1'b0, limit_q};
  endfunction

  // apply one item to the predicted state and return the point it reports
  function automatic out_item_t advance_point(in_item_t it);
    longint    x, y, z, a, b, c, dt;
    longint    fx, fy, fz, nx, ny, nz;
    out_item_t r;
    x  = px_q;
    y  = py_q;
    z  = pz_q;
    a  = sigma_q;
    b  = rho_q;
    c  = beta_q;
    dt = DT_Q16;
    if (it.operation == OP_LOAD) begin
      px_q    = it.start_x;
      py_q    = it.start_y;
      pz_q    = it.start_z;
      clock_q = '0;
      steps_q = '0;
    end else if (!at_last_point()) begin
      // derivatives, all from the old point
      fx = qmul(a, sat32(y - x));
      fy = sat32(qmul(x, sat32(b - z)) - y);
      fz = sat32(qmul(x, y) - qmul(c, z));
      nx = sat32(x + qmul(fx, dt));
      ny = sat32(y + qmul(fy, dt));
      nz = sat32(z + qmul(fz, dt));
      px_q    = nx[31:0];
      py_q    = ny[31:0];
      pz_q    = nz[31:0];
      clock_q = clock_q + DT_Q16;
      steps_q = steps_q + 20'd1;
    end
    r.time_now  = clock_q[30:0];
    r.pos_x     = px_q;
    r.pos_y     = py_q;
    r.pos_z     = pz_q;
    r.last_step = at_last_point();
    return r;
  endfunction

  // track accepted items and register writes
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      points_due.push_back(advance_point(in_item_i));
    end
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_COEF_A:     sigma_q = cfg_data_i;
        CFG_COEF_B:     rho_q   = cfg_data_i;
        CFG_COEF_C:     beta_q  = cfg_data_i;
        CFG_STEP_LIMIT: limit_q = cfg_data_i[19:0];
        default: ;
      endcase
    end
  end

  task automatic check_field(string fname, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      n_mismatch++;
    end
  endtask

  // compare every result with the oldest expected point
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (points_due.size() == 0) begin
        $error("result with no item pending: %p", out_item_o);
        n_mismatch++;
      end else begin
        want = points_due.pop_front();
        check_field("time_now", want.time_now, out_item_o.time_now);
        check_field("pos_x", want.pos_x, out_item_o.pos_x);
        check_field("pos_y", want.pos_y, out_item_o.pos_y);
        check_field("pos_z", want.pos_z, out_item_o.pos_z);
        check_field("last_step", want.last_step, out_item_o.last_step);
      end
    end
  end

  // receiver stalls
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // end the run if nothing moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("status: fail");
    $finish;
  end

  // item builders
  function automatic in_item_t load_item(logic signed [31:0] x, logic signed [31:0] y,
                                         logic signed [31:0] z);
    in_item_t it;
    it.operation = OP_LOAD;
    it.start_x   = x;
    it.start_y   = y;
    it.start_z   = z;
    return it;
  endfunction

  // start fields carry junk, the block must ignore them
  function automatic in_item_t step_item();
    in_item_t it;
    it.operation = OP_STEP;
    it.start_x   = $urandom;
    it.start_y   = $urandom;
    it.start_z   = $urandom;
    return it;
  endfunction

  function automatic logic signed [31:0] rand_near(int unsigned mag);
    return $signed($urandom_range(2 * mag)) - $signed(mag);
  endfunction

  function automatic logic signed [31:0] rand_start();
    if ($urandom_range(4) == 0) return $urandom;
    return rand_near(StartSpan);
  endfunction

  function automatic in_item_t rand_load();
    return load_item(rand_start(), rand_start(), rand_start());
  endfunction

  // mostly plausible positive coefficients, sometimes anything
  function automatic logic [31:0] pick_coef(int unsigned whole);
    if ($urandom_range(4) == 0) return $urandom;
    return $urandom_range(whole * 65536);
  endfunction

  // sender: random gaps, valid held until the item is taken
  task automatic send_item(in_item_t it);
    @(negedge clk_i);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // stop sending and let every pending result drain
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (points_due.size() != 0) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic restore_defaults();
    cfg_write(CFG_COEF_A, COEF_A_RST);
    cfg_write(CFG_COEF_B, COEF_B_RST);
    cfg_write(CFG_COEF_C, COEF_C_RST);
    cfg_write(CFG_STEP_LIMIT, 32'(STEP_LIMIT_RST));
  endtask

  // random register settings between trajectories
  task automatic shuffle_config();
    logic [31:0]        lim;
    logic [CfgIdxW-1:0] spare_idx;
    lim = $urandom;
    case ($urandom_range(9))
      0: lim[19:0] = '0;
      1: lim[19:0] = '1;
      2: lim[19:0] = STEP_LIMIT_RST;
      3: ;
      default: lim[19:0] = 20'($urandom_range(1, 48));
    endcase
    if ($urandom_range(1) == 0) cfg_write(CFG_STEP_LIMIT, lim);
    if ($urandom_range(3) == 0) cfg_write(CFG_COEF_A, pick_coef(20));
    if ($urandom_range(3) == 0) cfg_write(CFG_COEF_B, pick_coef(50));
    if ($urandom_range(3) == 0) cfg_write(CFG_COEF_C, pick_coef(5));
    if ($urandom_range(7) == 0) begin
      spare_idx = CfgIdxW'($urandom_range(2 ** CfgIdxW - 1, int'(CFG_STEP_LIMIT) + 1));
      cfg_write(spare_idx, $urandom);
    end
  endtask

  // steps before any load start from the cleared point
  task automatic test_unloaded_steps();
    send_item(step_item());
    send_item(step_item());
  endtask

  // extreme start points and saturation on the first step
  task automatic test_load_extremes();
    send_item(load_item(S32_MAX, S32_MAX, S32_MAX));
    send_item(step_item());
    send_item(load_item(S32_MIN, S32_MIN, S32_MIN));
    send_item(step_item());
    send_item(load_item(S32_MAX, S32_MIN, '0));
    send_item(step_item());
    send_item(load_item('0, '0, '0));
    send_item(load_item(Q_ONE, Q_ONE, Q_ONE));
    send_item(step_item());
    send_item(step_item());
  endtask

  // step limit of one, zero and two: flag and held state
  task automatic test_limit_edges();
    wait_idle();
    cfg_write(CFG_STEP_LIMIT, 32'd1);
    send_item(load_item(Q_ONE, Q_ONE, Q_ONE));
    send_item(step_item());
    send_item(step_item());
    wait_idle();
    cfg_write(CFG_STEP_LIMIT, 32'd0);
    send_item(load_item(Q_ONE, -Q_ONE, Q_ONE));
    send_item(step_item());
    wait_idle();
    cfg_write(CFG_STEP_LIMIT, 32'd2);
    send_item(load_item(-Q_ONE, Q_ONE, Q_ONE));
    send_item(step_item());
    send_item(step_item());
    wait_idle();
    cfg_write(CFG_STEP_LIMIT, 32'(STEP_LIMIT_RST));
  endtask

  // coefficients at both ends, and a write to an unused index
  task automatic test_coef_extremes();
    wait_idle();
    cfg_write(CFG_COEF_A, S32_MAX);
    cfg_write(CFG_COEF_B, S32_MIN);
    cfg_write(CFG_COEF_C, S32_MAX);
    send_item(step_item());
    wait_idle();
    cfg_write(CFG_COEF_A, S32_MIN);
    cfg_write(CFG_COEF_B, S32_MAX);
    cfg_write(CFG_COEF_C, S32_MIN);
    send_item(step_item());
    wait_idle();
    cfg_write('1, '1);
    send_item(step_item());
    wait_idle();
    restore_defaults();
  endtask

  // trajectories: usually a load, a run of steps, now and then a reload
  task automatic test_random_trajectories(int unsigned n_goal);
    int unsigned n_sent;
    int unsigned run_len;
    n_sent = 0;
    while (n_sent < n_goal) begin
      wait_idle();
      shuffle_config();
      if ($urandom_range(9) < 8) begin
        send_item(rand_load());
        n_sent++;
      end
      run_len = $urandom_range(40, 1);
      repeat (run_len) begin
        if ($urandom_range(19) == 0) send_item(rand_load());
        else send_item(step_item());
        n_sent++;
      end
    end
  endtask

  // same traffic with no gaps and no stalls
  task automatic test_full_rate(int unsigned n_goal);
    idle_pct  = 0;
    stall_pct = 0;
    test_random_trajectories(n_goal);
    wait_idle();
    idle_pct  = 20;
    stall_pct = 20;
  endtask

  initial begin : run
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_item_i   <= '0;
    out_ready_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_unloaded_steps();
    test_load_extremes();
    test_limit_edges();
    test_coef_extremes();
    test_random_trajectories(300);
    test_full_rate(60);
    test_random_trajectories(110);

    wait_idle();
    repeat (TailCycles) @(posedge clk_i);
    if (n_mismatch == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/les_pkg.sv
design/les_sermul.sv
design/lorenz_euler_step_top.sv
dv/lorenz_euler_step_top_tb.sv
